// ===== sv/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FSR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/fsr_pkg.sv =====
// shared types, widths and codes of the fenwick sum and rank count unit
package fsr_pkg;

	localparam int FUNC_W = 2;
	localparam int IDX_W = 17;
	localparam int VAL_W = 18;
	localparam int SUM_W = 34;
	localparam int CNT_W = 17;

	localparam int DEF_SIZE = 65536;
	localparam int DEF_VALUE_MAX = 131072;

	localparam logic [FUNC_W-1:0] FN_CHANGE = 2'd0;
	localparam logic [FUNC_W-1:0] FN_RSUM = 2'd1;
	localparam logic [FUNC_W-1:0] FN_COUNT = 2'd2;

	localparam logic KIND_SUM = 1'b0;
	localparam logic KIND_CNT = 1'b1;

	typedef enum logic {
		OP_UPD = 1'b0,
		OP_PFX = 1'b1
	} walk_op_t;

	typedef enum logic [2:0] {
		U_CLEAR = 3'b001,
		U_IDLE = 3'b010,
		U_WALK = 3'b100
	} unit_state_t;

	typedef struct packed {
		logic start;
		walk_op_t op;
	} walk_ctl_t;

	typedef struct packed {
		logic ready;
		logic idle;
		logic done;
	} walk_sts_t;

endpackage

// ===== sv/fenwick_sum_and_rank_count_unit.sv =====
// top level: request sequencer over the sum tree and count tree units
// change: a sum tree update walk, overlapped with up to two count tree walks (old value out, new value in)
// range sum: two prefix walks in turn (right end, then left end minus one), plus the result beat
// count: one prefix walk of the count tree, plus the result beat
// one item at a time; each tree memory reads and writes one node per cycle
// reset: stall held while both memories are cleared
`include "assert_macros.svh"

module fenwick_sum_and_rank_count_unit #(
	parameter int SIZE = fsr_pkg::DEF_SIZE,
	parameter int VALUE_MAX = fsr_pkg::DEF_VALUE_MAX
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [fsr_pkg::FUNC_W-1:0] func,
	input logic [fsr_pkg::IDX_W-1:0] index,
	input logic [fsr_pkg::VAL_W-1:0] new_value,
	input logic [fsr_pkg::IDX_W-1:0] left_end,
	input logic [fsr_pkg::IDX_W-1:0] right_end,
	input logic [fsr_pkg::VAL_W-1:0] threshold,
	output logic out_valid,
	input logic out_stall,
	output logic kind,
	output logic [fsr_pkg::SUM_W-1:0] answer,
	output logic bad_request
);

	localparam int AW = $clog2(SIZE+1);
	localparam int VW = $clog2(VALUE_MAX+1);
	localparam int SW = fsr_pkg::SUM_W;
	localparam int IW = fsr_pkg::IDX_W;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_DISPATCH = 10'b0000000010,
		ST_CHG_OLD = 10'b0000000100,
		ST_CHG_DEC = 10'b0000001000,
		ST_CHG_INC = 10'b0000010000,
		ST_CHG_SUM = 10'b0000100000,
		ST_RS_R = 10'b0001000000,
		ST_RS_L = 10'b0010000000,
		ST_CNT_W = 10'b0100000000,
		ST_RESULT = 10'b1000000000
	} top_state_t;

	top_state_t state_q;
	logic out_valid_q;

	logic [fsr_pkg::FUNC_W-1:0] func_q;
	logic [IW-1:0] index_q, left_q, right_q;
	logic [fsr_pkg::VAL_W-1:0] new_value_q, threshold_q;
	logic [SW-1:0] right_acc_q;
	logic res_kind_q, res_bad_q;
	logic [SW-1:0] res_ans_q;
	logic kind_q, bad_q;
	logic [SW-1:0] answer_q;

	fsr_pkg::walk_ctl_t sum_ctl, cnt_ctl;
	fsr_pkg::walk_sts_t sum_sts, cnt_sts;
	logic [AW-1:0] sum_pos;
	logic [VW-1:0] cnt_val, newv_sat, thr_sat, old_val;
	logic sum_old_valid, cnt_up;
	logic [SW-1:0] sum_acc;
	logic [fsr_pkg::CNT_W-1:0] cnt_acc;
	logic idx_bad, rng_bad, in_accept, out_load;

	always_comb begin
		idx_bad = index_q == '0 || 32'(index_q) > 32'(SIZE);
		rng_bad = left_q == '0 || right_q == '0 || 32'(left_q) > 32'(SIZE)
			|| 32'(right_q) > 32'(SIZE) || left_q > right_q;
		newv_sat = (32'(new_value_q) > 32'(VALUE_MAX)) ? VW'(VALUE_MAX) : VW'(new_value_q);
		thr_sat = (32'(threshold_q) > 32'(VALUE_MAX)) ? VW'(VALUE_MAX) : VW'(threshold_q);

		in_stall = !(state_q == ST_IDLE && sum_sts.ready && cnt_sts.ready);
		in_accept = in_valid && !in_stall;
		out_load = state_q == ST_RESULT && (!out_valid_q || !out_stall);

		sum_ctl.start = (state_q == ST_DISPATCH && ((func_q == fsr_pkg::FN_CHANGE && !idx_bad)
			|| (func_q == fsr_pkg::FN_RSUM && !rng_bad)))
			|| (state_q == ST_RS_R && sum_sts.done);
		sum_ctl.op = (state_q == ST_DISPATCH && func_q == fsr_pkg::FN_CHANGE)
			? fsr_pkg::OP_UPD : fsr_pkg::OP_PFX;
		if (state_q == ST_DISPATCH) begin
			sum_pos = (func_q == fsr_pkg::FN_CHANGE) ? AW'(index_q) : AW'(right_q);
		end else begin
			sum_pos = AW'(left_q - IW'(1));
		end

		// old value leaves its count first, then the new value is counted
		cnt_ctl.start = (state_q == ST_DISPATCH && func_q == fsr_pkg::FN_COUNT)
			|| (state_q == ST_CHG_OLD && sum_old_valid && (old_val != '0 || newv_sat != '0))
			|| (state_q == ST_CHG_DEC && cnt_sts.done && newv_sat != '0);
		cnt_ctl.op = (state_q == ST_DISPATCH) ? fsr_pkg::OP_PFX : fsr_pkg::OP_UPD;
		cnt_up = (state_q == ST_CHG_OLD) ? (old_val == '0) : 1'b1;
		if (state_q == ST_DISPATCH) cnt_val = thr_sat;
		else if (state_q == ST_CHG_OLD && old_val != '0) cnt_val = old_val;
		else cnt_val = newv_sat;
	end

	fsr_sum_unit #(
		.SIZE(SIZE),
		.VALUE_MAX(VALUE_MAX)
	) u_sum (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(sum_ctl),
		.pos(sum_pos),
		.new_val(newv_sat),
		.sts(sum_sts),
		.old_valid(sum_old_valid),
		.old_val(old_val),
		.acc(sum_acc)
	);

	fsr_cnt_unit #(
		.VALUE_MAX(VALUE_MAX)
	) u_cnt (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(cnt_ctl),
		.up(cnt_up),
		.val(cnt_val),
		.sts(cnt_sts),
		.acc(cnt_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_accept) state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					case (func_q)
						fsr_pkg::FN_CHANGE: state_q <= idx_bad ? ST_RESULT : ST_CHG_OLD;
						fsr_pkg::FN_RSUM: state_q <= rng_bad ? ST_RESULT : ST_RS_R;
						fsr_pkg::FN_COUNT: state_q <= ST_CNT_W;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_CHG_OLD: begin
					if (sum_old_valid) begin
						if (old_val != '0) state_q <= ST_CHG_DEC;
						else if (newv_sat != '0) state_q <= ST_CHG_INC;
						else state_q <= ST_CHG_SUM;
					end
				end
				ST_CHG_DEC: begin
					if (cnt_sts.done) state_q <= (newv_sat != '0) ? ST_CHG_INC : ST_CHG_SUM;
				end
				ST_CHG_INC: begin
					if (cnt_sts.done) state_q <= ST_CHG_SUM;
				end
				ST_CHG_SUM: begin
					if (sum_sts.idle) state_q <= ST_IDLE;
				end
				ST_RS_R: begin
					if (sum_sts.done) state_q <= ST_RS_L;
				end
				ST_RS_L: begin
					if (sum_sts.done) state_q <= ST_RESULT;
				end
				ST_CNT_W: begin
					if (cnt_sts.done) state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q <= func;
			index_q <= index;
			new_value_q <= new_value;
			left_q <= left_end;
			right_q <= right_end;
			threshold_q <= threshold;
		end
		// error answer by default, overwritten by a finished query
		if (state_q == ST_DISPATCH) begin
			res_kind_q <= fsr_pkg::KIND_SUM;
			res_ans_q <= '0;
			res_bad_q <= 1'b1;
		end
		if (state_q == ST_RS_R && sum_sts.done) right_acc_q <= sum_acc;
		if (state_q == ST_RS_L && sum_sts.done) begin
			res_kind_q <= fsr_pkg::KIND_SUM;
			res_ans_q <= right_acc_q - sum_acc;
			res_bad_q <= 1'b0;
		end
		if (state_q == ST_CNT_W && cnt_sts.done) begin
			res_kind_q <= fsr_pkg::KIND_CNT;
			res_ans_q <= SW'(cnt_acc);
			res_bad_q <= 1'b0;
		end
		if (out_load) begin
			kind_q <= res_kind_q;
			answer_q <= res_ans_q;
			bad_q <= res_bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign answer = answer_q;
	assign bad_request = bad_q;

	`FSR_ASSERT(a_sum_start_idle, clk, arst_n, sum_ctl.start |-> sum_sts.idle, "sum tree started while busy")
	`FSR_ASSERT(a_cnt_start_idle, clk, arst_n, cnt_ctl.start |-> cnt_sts.idle, "count tree started while busy")
	`FSR_ASSERT(a_out_from_result, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_RESULT), "result beat without a finished request")
	`FSR_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, in_valid && !in_stall, state_q == ST_DISPATCH, "accepted beat not dispatched")

endmodule

// ===== sv/fsr_sum_unit.sv =====
// element value and sum tree memory with its update and prefix walker
module fsr_sum_unit #(
	parameter int SIZE = fsr_pkg::DEF_SIZE,
	parameter int VALUE_MAX = fsr_pkg::DEF_VALUE_MAX
) (
	input logic clk,
	input logic arst_n,
	input fsr_pkg::walk_ctl_t ctl,
	input logic [$clog2(SIZE+1)-1:0] pos,
	input logic [$clog2(VALUE_MAX+1)-1:0] new_val,
	output fsr_pkg::walk_sts_t sts,
	output logic old_valid,
	output logic [$clog2(VALUE_MAX+1)-1:0] old_val,
	output logic [fsr_pkg::SUM_W-1:0] acc
);

	localparam int AW = $clog2(SIZE+1);
	localparam int PW = AW + 1;
	localparam int VW = $clog2(VALUE_MAX+1);
	localparam int SW = fsr_pkg::SUM_W;
	localparam int DW = VW + SW;

	fsr_pkg::unit_state_t state_q;
	logic [AW-1:0] clr_q;
	logic done_q;

	logic [PW-1:0] a_q;
	logic first_q;
	fsr_pkg::walk_op_t op_q;
	logic [SW-1:0] delta_q;
	logic [VW-1:0] newv_q;
	logic [SW-1:0] acc_q;
	logic [DW-1:0] rdata_q;

	logic [DW-1:0] mem [0:SIZE];

	logic [PW-1:0] low, nxt_up, nxt_dn, nxt;
	logic last, walking;
	logic [VW-1:0] rd_elem;
	logic [SW-1:0] rd_sum, delta_now;
	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [DW-1:0] wr_data;

	always_comb begin
		rd_elem = rdata_q[DW-1:SW];
		rd_sum = rdata_q[SW-1:0];
		low = a_q & (~a_q + PW'(1));
		nxt_up = a_q + low;
		nxt_dn = a_q - low;
		if (op_q == fsr_pkg::OP_UPD) begin
			nxt = nxt_up;
			last = nxt_up > PW'(SIZE);
		end else begin
			nxt = nxt_dn;
			last = nxt_dn == '0;
		end
		walking = state_q == fsr_pkg::U_WALK;
		// first node sees the old element, later nodes reuse its difference
		delta_now = first_q ? ({{(SW-VW){1'b0}}, newv_q} - {{(SW-VW){1'b0}}, rd_elem})
			: delta_q;

		wr_en = 1'b0;
		wr_addr = a_q[AW-1:0];
		wr_data = {first_q ? newv_q : rd_elem, rd_sum + delta_now};
		if (state_q == fsr_pkg::U_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (walking && op_q == fsr_pkg::OP_UPD) begin
			wr_en = 1'b1;
		end

		rd_en = 1'b0;
		rd_addr = pos;
		if (state_q == fsr_pkg::U_IDLE && ctl.start) begin
			rd_en = 1'b1;
		end else if (walking && !last) begin
			rd_en = 1'b1;
			rd_addr = nxt[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsr_pkg::U_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			// prefix of position zero is empty
			done_q <= (state_q == fsr_pkg::U_IDLE && ctl.start
				&& ctl.op == fsr_pkg::OP_PFX && pos == '0)
				|| (state_q == fsr_pkg::U_WALK && last);
			case (state_q)
				fsr_pkg::U_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(SIZE)) state_q <= fsr_pkg::U_IDLE;
				end
				fsr_pkg::U_IDLE: begin
					if (ctl.start && !(ctl.op == fsr_pkg::OP_PFX && pos == '0))
						state_q <= fsr_pkg::U_WALK;
				end
				fsr_pkg::U_WALK: begin
					if (last) state_q <= fsr_pkg::U_IDLE;
				end
				default: state_q <= fsr_pkg::U_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fsr_pkg::U_IDLE && ctl.start) begin
			a_q <= PW'(pos);
			op_q <= ctl.op;
			first_q <= 1'b1;
			newv_q <= new_val;
			acc_q <= '0;
		end else if (walking) begin
			first_q <= 1'b0;
			delta_q <= delta_now;
			acc_q <= acc_q + rd_sum;
			if (!last) a_q <= nxt;
		end
	end

	always_comb begin
		sts.ready = state_q != fsr_pkg::U_CLEAR;
		sts.idle = state_q == fsr_pkg::U_IDLE;
		sts.done = done_q;
		old_valid = walking && first_q && op_q == fsr_pkg::OP_UPD;
		old_val = rd_elem;
		acc = acc_q;
	end

endmodule

// ===== sv/fsr_cnt_unit.sv =====
// value count tree memory with its update and prefix walker
module fsr_cnt_unit #(
	parameter int VALUE_MAX = fsr_pkg::DEF_VALUE_MAX
) (
	input logic clk,
	input logic arst_n,
	input fsr_pkg::walk_ctl_t ctl,
	input logic up,
	input logic [$clog2(VALUE_MAX+1)-1:0] val,
	output fsr_pkg::walk_sts_t sts,
	output logic [fsr_pkg::CNT_W-1:0] acc
);

	localparam int AW = $clog2(VALUE_MAX+1);
	localparam int PW = AW + 1;
	localparam int CW = fsr_pkg::CNT_W;

	fsr_pkg::unit_state_t state_q;
	logic [AW-1:0] clr_q;
	logic done_q;

	logic [PW-1:0] a_q;
	fsr_pkg::walk_op_t op_q;
	logic up_q;
	logic [CW-1:0] acc_q;
	logic [CW-1:0] rdata_q;

	logic [CW-1:0] mem [0:VALUE_MAX];

	logic [PW-1:0] low, nxt_up, nxt_dn, nxt;
	logic last, walking;
	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [CW-1:0] wr_data;

	always_comb begin
		low = a_q & (~a_q + PW'(1));
		nxt_up = a_q + low;
		nxt_dn = a_q - low;
		if (op_q == fsr_pkg::OP_UPD) begin
			nxt = nxt_up;
			last = nxt_up > PW'(VALUE_MAX);
		end else begin
			nxt = nxt_dn;
			last = nxt_dn == '0;
		end
		walking = state_q == fsr_pkg::U_WALK;

		wr_en = 1'b0;
		wr_addr = a_q[AW-1:0];
		wr_data = up_q ? rdata_q + CW'(1) : rdata_q - CW'(1);
		if (state_q == fsr_pkg::U_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (walking && op_q == fsr_pkg::OP_UPD) begin
			wr_en = 1'b1;
		end

		rd_en = 1'b0;
		rd_addr = val;
		if (state_q == fsr_pkg::U_IDLE && ctl.start) begin
			rd_en = 1'b1;
		end else if (walking && !last) begin
			rd_en = 1'b1;
			rd_addr = nxt[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsr_pkg::U_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			// threshold zero counts nothing
			done_q <= (state_q == fsr_pkg::U_IDLE && ctl.start
				&& ctl.op == fsr_pkg::OP_PFX && val == '0)
				|| (state_q == fsr_pkg::U_WALK && last);
			case (state_q)
				fsr_pkg::U_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(VALUE_MAX)) state_q <= fsr_pkg::U_IDLE;
				end
				fsr_pkg::U_IDLE: begin
					if (ctl.start && !(ctl.op == fsr_pkg::OP_PFX && val == '0))
						state_q <= fsr_pkg::U_WALK;
				end
				fsr_pkg::U_WALK: begin
					if (last) state_q <= fsr_pkg::U_IDLE;
				end
				default: state_q <= fsr_pkg::U_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fsr_pkg::U_IDLE && ctl.start) begin
			a_q <= PW'(val);
			op_q <= ctl.op;
			up_q <= up;
			acc_q <= '0;
		end else if (walking) begin
			acc_q <= acc_q + rdata_q;
			if (!last) a_q <= nxt;
		end
	end

	always_comb begin
		sts.ready = state_q != fsr_pkg::U_CLEAR;
		sts.idle = state_q == fsr_pkg::U_IDLE;
		sts.done = done_q;
		acc = acc_q;
	end

endmodule

// ===== test/tb_top.sv =====
// testbench of the fenwick sum and rank count unit: directed and random beats checked against a tree model
`timescale 1ns / 1ps

module tb_top;
	import fsr_pkg::*;

	localparam int N_ELEMS = DEF_SIZE;
	localparam int N_VALUES = DEF_VALUE_MAX;
	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD = 400;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] new_value;
		logic [IDX_W-1:0] left_end;
		logic [IDX_W-1:0] right_end;
		logic [VAL_W-1:0] threshold;
		bit wait_idle;
	} request_t;

	typedef struct {
		logic kind;
		logic [SUM_W-1:0] answer;
		logic bad;
	} answer_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [IDX_W-1:0] index = '0;
	logic [VAL_W-1:0] new_value = '0;
	logic [IDX_W-1:0] left_end = '0;
	logic [IDX_W-1:0] right_end = '0;
	logic [VAL_W-1:0] threshold = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [SUM_W-1:0] answer;
	logic bad_request;

	fenwick_sum_and_rank_count_unit #(
		.SIZE(N_ELEMS),
		.VALUE_MAX(N_VALUES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.index(index),
		.new_value(new_value),
		.left_end(left_end),
		.right_end(right_end),
		.threshold(threshold),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.answer(answer),
		.bad_request(bad_request)
	);

	// model state: element array and the two fenwick trees
	bit [VAL_W-1:0] element_store [1:N_ELEMS];
	bit [SUM_W-1:0] sum_nodes [1:N_ELEMS];
	bit [CNT_W-1:0] count_nodes [1:N_VALUES];

	request_t pending_requests[$];
	answer_t expected_answers[$];
	request_t next_req;
	answer_t due;

	int error_count = 0;
	int answers_checked = 0;
	int cycle_count = 0;
	logic in_fire = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int stall_mode = 0;
	int mode_left = 0;

	function automatic void add_to_sums(int pos, bit [SUM_W-1:0] delta);
		while (pos >= 1 && pos <= N_ELEMS) begin
			sum_nodes[pos] += delta;
			pos += pos & -pos;
		end
	endfunction

	function automatic bit [SUM_W-1:0] sum_upto(int pos);
		bit [SUM_W-1:0] acc;
		acc = '0;
		while (pos > 0) begin
			acc += sum_nodes[pos];
			pos -= pos & -pos;
		end
		return acc;
	endfunction

	function automatic void add_to_counts(int v, bit up);
		while (v >= 1 && v <= N_VALUES) begin
			if (up)
				count_nodes[v] += 1'b1;
			else
				count_nodes[v] -= 1'b1;
			v += v & -v;
		end
	endfunction

	function automatic bit [CNT_W-1:0] count_upto(int v);
		bit [CNT_W-1:0] acc;
		acc = '0;
		while (v > 0) begin
			acc += count_nodes[v];
			v -= v & -v;
		end
		return acc;
	endfunction

	// applies one accepted beat to the model and queues the answer it causes
	function automatic void update_trees_and_answer(request_t r);
		answer_t res;
		int pos;
		int newv;
		int oldv;
		int thr;
		res.kind = KIND_SUM;
		res.answer = '0;
		res.bad = 1'b1;
		case (r.func)
			FN_CHANGE: begin
				pos = int'(r.index);
				if (pos < 1 || pos > N_ELEMS) begin
					expected_answers.push_back(res);
				end else begin
					newv = (int'(r.new_value) > N_VALUES) ? N_VALUES : int'(r.new_value);
					oldv = int'(element_store[pos]);
					add_to_sums(pos, SUM_W'(newv) - SUM_W'(oldv));
					if (oldv != 0)
						add_to_counts(oldv, 1'b0);
					element_store[pos] = VAL_W'(newv);
					if (newv != 0)
						add_to_counts(newv, 1'b1);
				end
			end
			FN_RSUM: begin
				if (r.left_end == 0 || r.right_end == 0 || r.left_end > N_ELEMS ||
						r.right_end > N_ELEMS || r.left_end > r.right_end) begin
					expected_answers.push_back(res);
				end else begin
					res.bad = 1'b0;
					res.answer = sum_upto(int'(r.right_end)) - sum_upto(int'(r.left_end) - 1);
					expected_answers.push_back(res);
				end
			end
			FN_COUNT: begin
				thr = (int'(r.threshold) > N_VALUES) ? N_VALUES : int'(r.threshold);
				res.kind = KIND_CNT;
				res.bad = 1'b0;
				res.answer = SUM_W'(count_upto(thr));
				expected_answers.push_back(res);
			end
			default: begin
			end
		endcase
	endfunction

	// unused fields carry random noise
	function automatic request_t noisy_request(logic [FUNC_W-1:0] f);
		request_t r;
		r.func = f;
		r.index = IDX_W'($urandom);
		r.new_value = VAL_W'($urandom);
		r.left_end = IDX_W'($urandom);
		r.right_end = IDX_W'($urandom);
		r.threshold = VAL_W'($urandom);
		r.wait_idle = 1'b0;
		return r;
	endfunction

	task automatic queue_change(int idx, int val);
		request_t r;
		r = noisy_request(FN_CHANGE);
		r.index = IDX_W'(idx);
		r.new_value = VAL_W'(val);
		pending_requests.push_back(r);
	endtask

	task automatic queue_range_sum(int l, int r);
		request_t q;
		q = noisy_request(FN_RSUM);
		q.left_end = IDX_W'(l);
		q.right_end = IDX_W'(r);
		pending_requests.push_back(q);
	endtask

	task automatic queue_count(int t);
		request_t r;
		r = noisy_request(FN_COUNT);
		r.threshold = VAL_W'(t);
		pending_requests.push_back(r);
	endtask

	function automatic int pick_position(int base, int width);
		int k;
		int p;
		k = $urandom_range(0, 19);
		if (k < 17) begin
			p = base + $urandom_range(0, width - 1);
			if (p > N_ELEMS)
				p = N_ELEMS;
		end else if (k == 17) begin
			p = ($urandom_range(0, 1) != 0) ? N_ELEMS : 1;
		end else begin
			p = $urandom_range(0, 131071);
		end
		return p;
	endfunction

	function automatic int pick_value();
		int k;
		k = $urandom_range(0, 19);
		if (k < 14)
			return $urandom_range(1, 32);
		else if (k < 16)
			return $urandom_range(1, N_VALUES);
		else if (k == 16)
			return 0;
		else if (k == 17)
			return N_VALUES;
		else
			return $urandom_range(N_VALUES + 1, 262143);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// sender: bursts of beats with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() != 0 &&
					(!pending_requests[0].wait_idle || expected_answers.size() == 0)) begin
				next_req = pending_requests.pop_front();
				func <= next_req.func;
				index <= next_req.index;
				new_value <= next_req.new_value;
				left_end <= next_req.left_end;
				right_end <= next_req.right_end;
				threshold <= next_req.threshold;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall: one long hold-off, otherwise a changing pattern
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && answers_checked >= 200) begin
			long_hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(50, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				2: out_stall <= (cycle_count % 5 < 2);
				default: out_stall <= ($urandom_range(0, 2) != 0);
			endcase
		end
	end

	// accepted beats feed the model, answer beats are checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				update_trees_and_answer('{func, index, new_value, left_end, right_end,
					threshold, 1'b0});
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					$display("%0t: answer beat with nothing expected: kind %0d answer %0d bad %0d",
						$time, kind, answer, bad_request);
					error_count++;
				end else begin
					due = expected_answers.pop_front();
					if (kind !== due.kind) begin
						$display("%0t: kind expected %0d, got %0d", $time, due.kind, kind);
						error_count++;
					end
					if (answer !== due.answer) begin
						$display("%0t: answer expected %0d, got %0d", $time, due.answer, answer);
						error_count++;
					end
					if (bad_request !== due.bad) begin
						$display("%0t: bad_request expected %0d, got %0d", $time, due.bad,
							bad_request);
						error_count++;
					end
				end
				answers_checked++;
			end
		end
		in_fire <= arst_n && in_valid && !in_stall;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		request_t r;
		int n;
		int sel;
		int k;
		int l;
		int rr;
		int win_base;
		int win_width;
		int last;

		// directed: empty trees, bad indexes, saturation, absent and re-written elements
		queue_count(0);
		queue_range_sum(1, N_ELEMS);
		queue_change(0, 9);
		queue_change(N_ELEMS + 1, 9);
		queue_change(131071, 262143);
		queue_change(1, 1);
		queue_change(N_ELEMS, N_VALUES);
		queue_change(2, 262143);
		queue_change(3, 5);
		queue_change(3, 7);
		queue_change(4, 0);
		queue_change(3, 0);
		queue_range_sum(1, N_ELEMS);
		pending_requests[pending_requests.size() - 1].wait_idle = 1'b1;
		queue_range_sum(1, 1);
		queue_range_sum(N_ELEMS, N_ELEMS);
		queue_range_sum(5, 4);
		queue_range_sum(0, 3);
		queue_range_sum(1, N_ELEMS + 1);
		queue_range_sum(131071, 131071);
		queue_count(1);
		queue_count(N_VALUES);
		queue_count(262143);
		r = noisy_request(FN_UNUSED);
		pending_requests.push_back(r);
		queue_count(6);

		// random: changes bunched in a moving window so elements get rewritten
		win_base = 1;
		win_width = 16;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n % 100 == 0) begin
				win_base = $urandom_range(1, N_ELEMS);
				win_width = $urandom_range(1, 64);
			end
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				queue_change(pick_position(win_base, win_width), pick_value());
			end else if (sel < 70) begin
				k = $urandom_range(0, 9);
				l = pick_position(win_base, win_width);
				if (k == 0) begin
					l = $urandom_range(0, 131071);
					rr = $urandom_range(0, 131071);
				end else if (k == 1) begin
					rr = (l > 1) ? l - 1 : 0;
				end else if (k == 2) begin
					l = 1;
					rr = N_ELEMS;
				end else begin
					rr = l + $urandom_range(0, win_width);
					if (rr > N_ELEMS)
						rr = N_ELEMS;
				end
				queue_range_sum(l, rr);
			end else if (sel < 95) begin
				k = $urandom_range(0, 9);
				if (k < 5)
					queue_count($urandom_range(0, 40));
				else if (k < 8)
					queue_count($urandom_range(0, N_VALUES));
				else
					queue_count($urandom_range(0, 262143));
			end else begin
				r = noisy_request(FN_UNUSED);
				pending_requests.push_back(r);
			end
			if (sel < 95)
				n++;
			if ($urandom_range(0, 149) == 0) begin
				last = pending_requests.size() - 1;
				pending_requests[last].wait_idle = 1'b1;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
